/* src/cqp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the circular queue with peek.
package cqp_pkg;

	localparam int DATA_W    = 32;
	localparam int IDX_W     = 4;
	localparam int CAP_W     = 5;
	localparam int REQ_W     = 2;
	localparam int ST_W      = 2;
	localparam int CAP_RESET = 16;
	localparam int CAP_MIN   = 2;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD
	} cqp_state_t;

	// Controller to datapath
	typedef struct packed {
		logic latch;    // capture the request beat
		logic execute;  // update pointers, write or read the store
		logic load;     // move the result into the output register
	} cqp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_busy; // output register holds a beat that is not taken this cycle
	} cqp_sts_t;

endpackage

/* src/cqp_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: sequences accept, execute and result load.
module cqp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  cqp_pkg::cqp_sts_t sts,
	output cqp_pkg::cqp_cmd_t cmd
);
	import cqp_pkg::*;

	cqp_state_t state_q;
	cqp_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		req_ready   = 1'b0;
		cmd         = '0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.execute = 1'b1;
				state_nxt   = S_LOAD;
			end
			S_LOAD: begin
				if (!sts.out_busy) begin
					cmd.load  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

/* src/cqp_dp.sv */
`timescale 1ns / 1ps
// Datapath: slot store, head/tail pointers, capacity register and output register.
module cqp_dp #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cqp_pkg::cqp_cmd_t                  cmd,
	output cqp_pkg::cqp_sts_t                  sts,
	input  logic                               cfg_we,
	input  logic [cqp_pkg::CAP_W-1:0]          cfg_cap,
	input  logic [cqp_pkg::REQ_W-1:0]          in_req_type,
	input  logic signed [cqp_pkg::DATA_W-1:0]  in_data,
	input  logic [cqp_pkg::IDX_W-1:0]          in_peek_index,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [cqp_pkg::ST_W-1:0]           out_status,
	output logic signed [cqp_pkg::DATA_W-1:0]  out_value
);
	import cqp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int W  = (CW > CAP_W) ? CW : CAP_W;
	localparam int PW = ((CW > IDX_W) ? CW : IDX_W) + 2;

	logic signed [DATA_W-1:0] mem [DEPTH];

	// Captured request
	logic [REQ_W-1:0]         req_type_q;
	logic signed [DATA_W-1:0] req_data_q;
	logic [IDX_W-1:0]         req_idx_q;

	// Queue state
	logic [CAP_W-1:0] cap_q;
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    tail_q;
	logic             empty_q;

	// Result of the execute step
	logic [ST_W-1:0]          status_q;
	logic                     has_value_q;
	logic signed [DATA_W-1:0] rd_data_q;

	// Output register
	logic                     out_valid_q;
	logic [ST_W-1:0]          out_status_q;
	logic signed [DATA_W-1:0] out_value_q;

	// Effective capacity, clamped to 2..DEPTH
	logic [W-1:0]  cap_ext;
	logic [CW-1:0] eff_cap;
	logic [CW-1:0] tail_inc;
	logic [CW-1:0] head_inc;
	logic [AW-1:0] tail_next;
	logic [AW-1:0] head_next;
	logic [PW-1:0] count;
	logic [PW-1:0] peek_sum;
	logic [AW-1:0] peek_pos;

	// Execute decisions
	logic [AW-1:0]   head_nxt;
	logic [AW-1:0]   tail_nxt;
	logic            empty_nxt;
	logic [ST_W-1:0] st_nxt;
	logic            has_value_nxt;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [AW-1:0]   rd_addr;

	always_comb begin
		cap_ext = W'(cap_q);
		if (cap_ext < W'(CAP_MIN)) begin
			eff_cap = CW'(CAP_MIN);
		end else if (cap_ext > W'(DEPTH)) begin
			eff_cap = CW'(DEPTH);
		end else begin
			eff_cap = CW'(cap_ext);
		end

		tail_inc  = CW'(tail_q) + CW'(1);
		tail_next = (tail_inc >= eff_cap) ? AW'(tail_inc - eff_cap) : AW'(tail_inc);
		head_inc  = CW'(head_q) + CW'(1);
		head_next = (head_inc >= eff_cap) ? AW'(head_inc - eff_cap) : AW'(head_inc);

		if (tail_q >= head_q) begin
			count = PW'(tail_q) - PW'(head_q) + PW'(1);
		end else begin
			count = PW'(tail_q) + PW'(eff_cap) - PW'(head_q) + PW'(1);
		end

		// idx stays below the count, so one wrap is enough
		peek_sum = PW'(head_q) + PW'(req_idx_q);
		peek_pos = (peek_sum >= PW'(eff_cap)) ? AW'(peek_sum - PW'(eff_cap))
		                                      : AW'(peek_sum);
	end

	always_comb begin
		head_nxt      = head_q;
		tail_nxt      = tail_q;
		empty_nxt     = empty_q;
		st_nxt        = ST_OK;
		has_value_nxt = 1'b0;
		wr_en         = 1'b0;
		wr_addr       = tail_next;
		rd_addr       = head_q;
		case (req_type_q)
			REQ_ENQ: begin
				if (empty_q) begin
					head_nxt  = '0;
					tail_nxt  = '0;
					empty_nxt = 1'b0;
					wr_en     = 1'b1;
					wr_addr   = '0;
				end else if (tail_next == head_q) begin
					st_nxt = ST_FULL;
				end else begin
					tail_nxt = tail_next;
					wr_en    = 1'b1;
				end
			end
			REQ_DEQ: begin
				if (empty_q) begin
					st_nxt = ST_EMPTY;
				end else begin
					has_value_nxt = 1'b1;
					if (head_q == tail_q) begin
						head_nxt  = '0;
						tail_nxt  = '0;
						empty_nxt = 1'b1;
					end else begin
						head_nxt = head_next;
					end
				end
			end
			REQ_PEEK: begin
				rd_addr = peek_pos;
				if (empty_q) begin
					st_nxt = ST_EMPTY;
				end else if (PW'(req_idx_q) >= count) begin
					st_nxt = ST_RANGE;
				end else begin
					has_value_nxt = 1'b1;
				end
			end
			default: begin
				st_nxt = ST_RANGE;
			end
		endcase
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_type_q <= in_req_type;
			req_data_q <= in_data;
			req_idx_q  <= in_peek_index;
		end
	end

	// Slot store, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.execute && wr_en) begin
			mem[wr_addr] <= req_data_q;
		end
		if (cmd.execute) begin
			rd_data_q <= mem[rd_addr];
			status_q  <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_W'(CAP_RESET);
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			has_value_q <= 1'b0;
		end else if (cfg_we) begin
			cap_q   <= cfg_cap;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.execute) begin
			head_q      <= head_nxt;
			tail_q      <= tail_nxt;
			empty_q     <= empty_nxt;
			has_value_q <= has_value_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_status_q <= status_q;
			out_value_q  <= has_value_q ? rd_data_q : '0;
		end
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_status   = out_status_q;
	assign out_value    = out_value_q;

endmodule

/* src/circular_queue_with_peek.sv */
`timescale 1ns / 1ps
// Top level of the circular queue with peek: ports, controller, datapath, checks.
//
// Ring-buffer queue of signed 32-bit words with DEPTH slots, of which the
// capacity register (cfg_data, reset 16) puts 2..DEPTH in use; values outside
// that range saturate. Every request beat (tuser: 0 enqueue, 1 dequeue,
// 2 peek) yields exactly one result beat: tuser carries the status
// (0 ok, 1 full, 2 empty, 3 index out of range or unknown request) and
// tdata the dequeued or peeked word, 0 otherwise. A peek reads position
// peek_index counted from the oldest entry without removing it. A capacity
// write empties the queue; write it only while no request is in flight.
// Flow: a request passes a pointer update with a registered store read,
// then the output load, before its result beat is presented; a new
// request is taken only after the last one loaded its result, and a stalled
// output holds the controller in its load step. The output register lets
// the next request be accepted while a result beat waits. No clearing pass
// after reset: the store is only read where it was written.
module circular_queue_with_peek #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [31:0] data_in, [35:32] peek_index, [39:36] zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
	// result channel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] value_out
	output logic [1:0]  m_axis_tuser,  // [1:0] status
	// capacity register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data       // capacity_in_use
);
	import cqp_pkg::*;

	cqp_cmd_t cmd;
	cqp_sts_t sts;
	logic     cfg_we;

	// config is always taken; the user writes it only while idle
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	cqp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cqp_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_cap       (cfg_data),
		.in_req_type   (s_axis_tuser),
		.in_data       (s_axis_tdata[31:0]),
		.in_peek_index (s_axis_tdata[35:32]),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.out_status    (m_axis_tuser),
		.out_value     (m_axis_tdata)
	);

`ifndef NO_ASSERTIONS
	// an execute step always follows a captured beat
	a_exec_after_latch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |-> $past(cmd.latch))
		else $error("execute without captured request");

	// a loaded result shows up as a result beat
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> m_axis_tvalid)
		else $error("loaded result not presented");

	// no new request is taken while one is still being worked on
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !(cmd.execute || cmd.load))
		else $error("request accepted while busy");

	// failed requests carry a zero word
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
		else $error("nonzero value on failed request");
`endif

endmodule

/* sim/circular_queue_with_peek_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the circular queue with peek: directed table, then random phases.
module circular_queue_with_peek_tb;
	import cqp_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;  // no operation behind this code
	localparam int SLOTS           = 16;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 60;
	localparam int DRAIN_CYCLES    = 8;   // margin after the last result beat
	localparam int LONG_HOLD       = 80;  // receiver back-pressure stretch, in cycles

	typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

	// One line of the directed plan. When typed is set, st/val is the result read
	// straight off the spec; otherwise the result comes from the queue model.
	typedef struct packed {
		row_kind_t   kind;
		logic [4:0]  cap;
		logic [1:0]  req;
		logic [31:0] data;
		logic [3:0]  idx;
		bit          typed;
		logic [1:0]  st;
		logic [31:0] val;
	} plan_row_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
	} queue_result_t;

	localparam plan_row_t PLAN [25] = '{
		// fresh from reset: capacity 16, queue empty
		'{ROW_REQ, 5'd0, REQ_DEQ,    32'h0000_0000, 4'd0,  1'b1, ST_EMPTY, 32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_PEEK,   32'h0000_0000, 4'd0,  1'b1, ST_EMPTY, 32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_UNUSED, 32'h0000_0000, 4'd0,  1'b1, ST_RANGE, 32'h0000_0000},
		// extremes of the word
		'{ROW_REQ, 5'd0, REQ_ENQ,    32'h8000_0000, 4'd0,  1'b1, ST_OK,    32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_ENQ,    32'h7FFF_FFFF, 4'd15, 1'b1, ST_OK,    32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_ENQ,    32'hFFFF_FFFF, 4'd0,  1'b1, ST_OK,    32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_PEEK,   32'h0000_0000, 4'd0,  1'b1, ST_OK,    32'h8000_0000},
		'{ROW_REQ, 5'd0, REQ_PEEK,   32'hFFFF_FFFF, 4'd2,  1'b1, ST_OK,    32'hFFFF_FFFF},
		// peek one past the newest, and at the top index
		'{ROW_REQ, 5'd0, REQ_PEEK,   32'h0000_0000, 4'd3,  1'b1, ST_RANGE, 32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_PEEK,   32'h0000_0000, 4'd15, 1'b1, ST_RANGE, 32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_DEQ,    32'h0000_0000, 4'd0,  1'b1, ST_OK,    32'h8000_0000},
		'{ROW_REQ, 5'd0, REQ_DEQ,    32'h0000_0000, 4'd0,  1'b1, ST_OK,    32'h7FFF_FFFF},
		'{ROW_REQ, 5'd0, REQ_DEQ,    32'h0000_0000, 4'd0,  1'b1, ST_OK,    32'hFFFF_FFFF},
		'{ROW_REQ, 5'd0, REQ_DEQ,    32'h0000_0000, 4'd0,  1'b1, ST_EMPTY, 32'h0000_0000},
		// capacity 0 saturates to two slots
		'{ROW_CFG, 5'd0, REQ_ENQ,    32'h0000_0000, 4'd0,  1'b0, ST_OK,    32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_ENQ,    32'h0000_0001, 4'd0,  1'b1, ST_OK,    32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_ENQ,    32'h5A5A_A5A5, 4'd0,  1'b1, ST_OK,    32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_ENQ,    32'hDEAD_BEEF, 4'd0,  1'b1, ST_FULL,  32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_PEEK,   32'h0000_0000, 4'd1,  1'b1, ST_OK,    32'h5A5A_A5A5},
		'{ROW_REQ, 5'd0, REQ_DEQ,    32'h0000_0000, 4'd0,  1'b1, ST_OK,    32'h0000_0001},
		// tail wraps to slot zero, peek across the wrap
		'{ROW_REQ, 5'd0, REQ_ENQ,    32'h1234_5678, 4'd0,  1'b0, ST_OK,    32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_PEEK,   32'h0000_0000, 4'd1,  1'b0, ST_OK,    32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_DEQ,    32'h0000_0000, 4'd0,  1'b0, ST_OK,    32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_DEQ,    32'h0000_0000, 4'd0,  1'b0, ST_OK,    32'h0000_0000},
		'{ROW_REQ, 5'd0, REQ_UNUSED, 32'hFFFF_FFFF, 4'd15, 1'b1, ST_RANGE, 32'h0000_0000}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // [31:0] data_in, [35:32] peek_index, [39:36] zero
	logic [1:0]  s_axis_tuser = '0;  // [1:0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;       // [31:0] value_out
	logic [1:0]  m_axis_tuser;       // [1:0] status
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data = '0;

	circular_queue_with_peek #(.DEPTH(SLOTS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// Queue model state, kept in step with every accepted beat
	logic [31:0] slot_image [SLOTS];
	int          head_slot = 0;
	int          tail_slot = 0;
	bit          model_empty = 1'b1;
	logic [4:0]  cap_reg = 5'(CAP_RESET);

	queue_result_t awaited_results [$];
	queue_result_t oldest;
	int burst_left = 0;
	int hold_asks = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int cap_writes = 0;
	int fail_count = 0;
	int status_seen [4] = '{0, 0, 0, 0};

	initial begin
		forever #5 clk = ~clk;
	end

	// Register values outside 2..SLOTS saturate
	function automatic int active_slots();
		int c;
		c = int'(cap_reg);
		if (c < CAP_MIN) c = CAP_MIN;
		if (c > SLOTS) c = SLOTS;
		return c;
	endfunction

	function automatic int words_held();
		if (model_empty) return 0;
		if (tail_slot >= head_slot) return tail_slot - head_slot + 1;
		return tail_slot + active_slots() - head_slot + 1;
	endfunction

	task automatic compute_queue_response(input logic [1:0] req, input logic [31:0] data,
			input logic [3:0] idx, output logic [1:0] st, output logic [31:0] val);
		int cap;
		int nxt;
		int p;
		begin
			cap = active_slots();
			st = ST_OK;
			val = '0;
			case (req)
				REQ_ENQ: begin
					nxt = (tail_slot + 1 >= cap) ? tail_slot + 1 - cap : tail_slot + 1;
					if (model_empty) begin
						// empty queue restarts at slot zero
						head_slot = 0;
						tail_slot = 0;
						model_empty = 1'b0;
						slot_image[0] = data;
					end else if (nxt == head_slot) begin
						st = ST_FULL;
					end else begin
						tail_slot = nxt;
						slot_image[nxt] = data;
					end
				end
				REQ_DEQ: begin
					if (model_empty) begin
						st = ST_EMPTY;
					end else begin
						val = slot_image[head_slot];
						if (head_slot == tail_slot) begin
							head_slot = 0;
							tail_slot = 0;
							model_empty = 1'b1;
						end else begin
							head_slot = (head_slot + 1 >= cap) ? head_slot + 1 - cap : head_slot + 1;
						end
					end
				end
				REQ_PEEK: begin
					if (model_empty) begin
						st = ST_EMPTY;
					end else if (int'(idx) >= words_held()) begin
						st = ST_RANGE;
					end else begin
						p = head_slot + int'(idx);
						if (p >= cap) p -= cap;
						val = slot_image[p];
					end
				end
				default: begin
					st = ST_RANGE;
				end
			endcase
		end
	endtask

	// Called and returns at a falling edge. Bursts of back-to-back beats with
	// random gaps in between; tvalid stays high across a burst.
	task automatic issue_request(input logic [1:0] req, input logic [31:0] data,
			input logic [3:0] idx, input bit typed, input queue_result_t typed_res);
		int gap;
		logic [1:0] st;
		logic [31:0] val;
		queue_result_t predicted;
		begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= {4'b0000, idx, data};
			s_axis_tuser <= req;
			do @(posedge clk); while (!s_axis_tready);
			compute_queue_response(req, data, idx, st, val);
			predicted.status = st;
			predicted.value = val;
			awaited_results.push_back(typed ? typed_res : predicted);
			requests_sent++;
			burst_left--;
			@(negedge clk);
		end
	endtask

	// Only while idle: all results back, and a drain margin for the pipeline
	task automatic write_capacity(input logic [4:0] v);
		begin
			s_axis_tvalid <= 1'b0;
			while (awaited_results.size() != 0) @(negedge clk);
			repeat (DRAIN_CYCLES) @(negedge clk);
			cfg_valid <= 1'b1;
			cfg_data <= v;
			do @(posedge clk); while (!cfg_ready);
			// a capacity write empties the queue; the store keeps its words
			cap_reg = v;
			head_slot = 0;
			tail_slot = 0;
			model_empty = 1'b1;
			cap_writes++;
			@(negedge clk);
			cfg_valid <= 1'b0;
			burst_left = 0;
		end
	endtask

	// Receiver: changes between always-ready, coin-flip and one-in-three
	// stretches; on request it holds off for a LONG_HOLD stretch so results back up.
	initial begin
		int mode;
		int mode_left;
		int tick;
		int holds_done;
		mode = 0;
		mode_left = 0;
		tick = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_asks != holds_done) begin
				holds_done++;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 60);
			end
			case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= (tick % 3 == 0);
			endcase
			mode_left--;
			tick++;
		end
	end

	// Result checker: every beat taken must match the oldest awaited result
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result beat: status %0d, value %h", m_axis_tuser, m_axis_tdata);
				fail_count++;
			end else begin
				oldest = awaited_results.pop_front();
				results_checked++;
				status_seen[oldest.status]++;
				if (m_axis_tuser !== oldest.status) begin
					$error("status: expected %0d, got %0d", oldest.status, m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata !== oldest.value) begin
					$error("value_out: expected %h, got %h", oldest.value, m_axis_tdata);
					fail_count++;
				end
			end
		end
	end

	initial begin
		logic [4:0] caps [PHASES];
		queue_result_t typed_res;
		int enq_pct;
		int deq_pct;
		int roll;
		int held;
		logic [1:0] req;
		logic [3:0] idx;
		foreach (slot_image[i]) slot_image[i] = '0;
		// both extremes, saturation on either side, and random middle settings
		caps[0] = 5'd31;
		caps[1] = 5'd16;
		caps[2] = 5'd1;
		caps[3] = 5'd3;
		caps[4] = 5'($urandom_range(4, 15));
		caps[5] = 5'($urandom_range(17, 30));
		caps[6] = 5'd2;
		caps[7] = 5'd16;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (PLAN[i]) begin
			if (PLAN[i].kind == ROW_CFG) begin
				write_capacity(PLAN[i].cap);
			end else begin
				typed_res.status = PLAN[i].st;
				typed_res.value = PLAN[i].val;
				issue_request(PLAN[i].req, PLAN[i].data, PLAN[i].idx, PLAN[i].typed, typed_res);
			end
		end

		// Random phases alternate between a strongly and a mildly enqueue-weighted
		// mix, with one capacity setting per phase.
		for (int ph = 0; ph < PHASES; ph++) begin
			write_capacity(caps[ph]);
			if (ph == 1) hold_asks <= hold_asks + 1;
			enq_pct = (ph % 2 == 0) ? 65 : 40;
			deq_pct = (ph % 2 == 0) ? 20 : 35;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				roll = $urandom_range(0, 99);
				held = words_held();
				idx = 4'($urandom());
				if (roll < enq_pct) begin
					req = REQ_ENQ;
				end else if (roll < enq_pct + deq_pct) begin
					req = REQ_DEQ;
				end else if (roll < 97) begin
					req = REQ_PEEK;
					// mostly valid positions, the rest a random index
					if (held != 0 && $urandom_range(0, 3) != 0) idx = 4'($urandom_range(0, held - 1));
				end else begin
					req = REQ_UNUSED;
				end
				typed_res = '0;
				issue_request(req, $urandom(), idx, 1'b0, typed_res);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Run covered %0d requests under %0d capacity writes, %0d results checked.",
			requests_sent, cap_writes, results_checked);
		$display("Statuses seen: ok %0d, full %0d, empty %0d, out of range %0d.",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_RANGE]);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
